[rtl/core/sine_voice_with_release_unit_defines.svh]
// assertion macros used by the voice rtl
`ifndef SINE_VOICE_WITH_RELEASE_UNIT_DEFINES_SVH
`define SINE_VOICE_WITH_RELEASE_UNIT_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define SVR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define SVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/svr_pkg.sv]
`timescale 1ns / 1ps

package svr_pkg;

    localparam int SAMPLE_RATE_DEF = 48000;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam logic [15:0] LEVEL_MUL  = 16'd9830;
    localparam logic [15:0] DECAY_MUL  = 16'd64881;
    localparam logic [15:0] GAIN_ONE   = 16'hFFFF;
    localparam logic [15:0] GAIN_FLOOR = 16'd327;

    localparam logic [63:0] SEMI_Q30    = 64'd1137589835;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LEVEL,
        S_RELEASE
    } state_t;

    typedef struct packed {
        logic start;
        logic stop;
        logic index;
        logic read;
        logic level;
        logic commit;
    } cmd_t;

endpackage

[rtl/core/svr_ctrl.sv]
`timescale 1ns / 1ps

module svr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [1:0]      action,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output svr_pkg::cmd_t   cmd
);

    svr_pkg::state_t state_reg;
    svr_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            out_free;
    logic            accept;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && (state_reg == svr_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svr_pkg::S_IDLE:
            begin
                if (accept && (action == svr_pkg::ACT_TICK))
                begin
                    state_next = svr_pkg::S_READ;
                end
            end
            svr_pkg::S_READ:
            begin
                state_next = svr_pkg::S_LEVEL;
            end
            svr_pkg::S_LEVEL:
            begin
                state_next = svr_pkg::S_RELEASE;
            end
            svr_pkg::S_RELEASE:
            begin
                if (out_free)
                begin
                    state_next = svr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = svr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            svr_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = accept && (action == svr_pkg::ACT_START);
                cmd.stop  = accept && (action == svr_pkg::ACT_STOP);
                cmd.index = accept && (action == svr_pkg::ACT_TICK);
            end
            svr_pkg::S_READ:
            begin
                cmd.read = 1'b1;
            end
            svr_pkg::S_LEVEL:
            begin
                cmd.level = 1'b1;
            end
            svr_pkg::S_RELEASE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svr_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/core/svr_datapath.sv]
`timescale 1ns / 1ps

module svr_datapath #(
    parameter int SAMPLE_RATE      = svr_pkg::SAMPLE_RATE_DEF,
    parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  svr_pkg::cmd_t       cmd,
    input  logic [6:0]          note,
    input  logic [15:0]         velocity,
    input  logic                allow_release,
    output logic signed [15:0]  sample,
    output logic                voice_active
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W = 32 + $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [63:0] STEP_DEN = 64'(SAMPLE_RATE) << 6;

    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];
    typedef logic [31:0] step_rom_t [128];

    function automatic logic signed [15:0] sine_entry(int unsigned i);
        logic [63:0]        frac64;
        logic [1:0]         quad;
        logic [63:0]        quad_pos;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        logic [15:0]        val;
        frac64   = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
        quad     = frac64[31:30];
        quad_pos = {34'd0, frac64[29:0]};
        if (quad[0])
        begin
            quad_pos = svr_pkg::ONE_Q30 - quad_pos;
        end
        x    = (quad_pos * svr_pkg::HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        mag = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        val = mag[15:0];
        return quad[1] ? -$signed(val) : $signed(val);
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            t[i] = sine_entry(i);
        end
        return t;
    endfunction

    function automatic step_rom_t build_steps();
        step_rom_t   t;
        logic [31:0] semi [12];
        logic [63:0] num;
        int          u;
        semi[0] = 32'd440 << 16;
        for (int k = 1; k < 12; k++)
        begin
            semi[k] = 32'(((64'(semi[k-1]) * svr_pkg::SEMI_Q30) + 64'd536870912) >> 30);
        end
        for (int n = 0; n < 128; n++)
        begin
            u    = n + 3;
            num  = 64'(semi[u % 12]) << (16 + u / 12);
            t[n] = 32'((num + STEP_DEN / 2) / STEP_DEN);
        end
        return t;
    endfunction

    function automatic logic signed [15:0] scale_q16(logic signed [15:0] a, logic [15:0] g);
        logic [15:0] mag;
        logic [31:0] prod;
        logic [15:0] r;
        mag  = a[15] ? 16'(-a) : a;
        prod = 32'(mag) * 32'(g) + 32'd32768;
        r    = prod[31:16];
        return a[15] ? -$signed(r) : $signed(r);
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam step_rom_t STEP_ROM = build_steps();

    logic [31:0]        phase_reg;
    logic [31:0]        phase_next;
    logic [31:0]        step_reg;
    logic [31:0]        step_next;
    logic [15:0]        level_reg;
    logic [15:0]        level_next;
    logic [15:0]        gain_reg;
    logic [15:0]        gain_next;
    logic               releasing_reg;
    logic               releasing_next;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [15:0] rom_q_reg;
    logic signed [15:0] s1_reg;
    logic signed [15:0] sample_reg;
    logic signed [15:0] sample_next;
    logic               active_reg;
    logic               active_next;

    logic [PROD_W-1:0]  idx_prod;
    logic [31:0]        level_prod;
    logic [31:0]        decay_prod;
    logic [15:0]        gain_dec;
    logic signed [15:0] s2;

    assign idx_prod   = PROD_W'(phase_reg) * PROD_W'(SINE_TABLE_DEPTH);
    assign level_prod = 32'(velocity) * 32'(svr_pkg::LEVEL_MUL) + 32'd32768;
    assign decay_prod = 32'(gain_reg) * 32'(svr_pkg::DECAY_MUL) + 32'd32768;
    assign gain_dec   = decay_prod[31:16];
    assign s2         = releasing_reg ? scale_q16(s1_reg, gain_reg) : s1_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        level_next     = level_reg;
        gain_next      = gain_reg;
        releasing_next = releasing_reg;
        sample_next    = sample_reg;
        active_next    = active_reg;
        priority if (cmd.start)
        begin
            phase_next     = '0;
            level_next     = level_prod[31:16];
            gain_next      = '0;
            releasing_next = 1'b0;
            step_next      = STEP_ROM[note];
        end
        else if (cmd.stop)
        begin
            if (allow_release)
            begin
                if (!releasing_reg)
                begin
                    releasing_next = 1'b1;
                    gain_next      = svr_pkg::GAIN_ONE;
                end
            end
            else
            begin
                step_next = '0;
            end
        end
        else if (cmd.commit)
        begin
            if (step_reg != '0)
            begin
                phase_next  = phase_reg + step_reg;
                sample_next = s2;
                active_next = 1'b1;
                if (releasing_reg)
                begin
                    if (gain_dec <= svr_pkg::GAIN_FLOOR)
                    begin
                        step_next      = '0;
                        releasing_next = 1'b0;
                        gain_next      = '0;
                        active_next    = 1'b0;
                    end
                    else
                    begin
                        gain_next = gain_dec;
                    end
                end
            end
            else
            begin
                sample_next = '0;
                active_next = 1'b0;
            end
        end
        else
        begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            step_reg      <= '0;
            level_reg     <= '0;
            gain_reg      <= '0;
            releasing_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            level_reg     <= level_next;
            gain_reg      <= gain_next;
            releasing_reg <= releasing_next;
        end
    end

    // sine rom with registered read, then the two scaling stages
    always_ff @(posedge clk)
    begin
        if (cmd.index)
        begin
            idx_reg <= idx_prod[32 +: IDX_W];
        end
        if (cmd.read)
        begin
            rom_q_reg <= SINE_ROM[idx_reg];
        end
        if (cmd.level)
        begin
            s1_reg <= scale_q16(rom_q_reg, level_reg);
        end
        sample_reg <= sample_next;
        active_reg <= active_next;
    end

    assign sample       = sample_reg;
    assign voice_active = active_reg;

endmodule

[rtl/core/sine_voice_with_release_unit.sv]
`timescale 1ns / 1ps
// One sine voice with exponential release. A tick item's sample appears on the
// result channel when the release step commits it (that step waits while a
// previous sample is still held there), and the input is ready again in the
// same cycle, so a new tick is taken only once the last one is committed. The
// phase-to-index multiply runs at acceptance, then come the registered sine rom
// read, the level multiply and the release multiply with the state update, in
// series. Start note, stop note and the unused action code give no result, and
// they are taken even while a sample waits to be read. The sine table and the
// note-to-increment table are built at elaboration, so there is no fill or
// clearing time after reset.

`include "sine_voice_with_release_unit_defines.svh"

module sine_voice_with_release_unit #(
    parameter int SAMPLE_RATE      = svr_pkg::SAMPLE_RATE_DEF,
    parameter int SINE_TABLE_DEPTH = svr_pkg::SINE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          action,
    input  logic [6:0]          note,
    input  logic [15:0]         velocity,
    input  logic                allow_release,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic signed [15:0]  sample,
    output logic                voice_active
);

    svr_pkg::cmd_t cmd;
    logic          tick_taken;

    assign tick_taken = req_valid && req_ready && (action == svr_pkg::ACT_TICK);

    svr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    svr_datapath #(
        .SAMPLE_RATE      (SAMPLE_RATE),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .note          (note),
        .velocity      (velocity),
        .allow_release (allow_release),
        .sample        (sample),
        .voice_active  (voice_active)
    );

    `SVR_ASSERT_NEXT(a_tick_blocks_input, tick_taken, !req_ready, "tick did not block input")
    `SVR_ASSERT_NOW(a_result_from_commit, $rose(rsp_valid), $past(cmd.commit), "stray result")
    `SVR_ASSERT_NOW(a_commit_needs_slot, cmd.commit, !rsp_valid || rsp_ready, "lost result")

endmodule

[bench/tb_sine_voice_with_release_unit.sv]
`timescale 1ns / 1ps

module tb_sine_voice_with_release_unit;
    import svr_pkg::*;

    typedef longint unsigned u64_t;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         DEPTH       = SINE_DEPTH_DEF;
    localparam int         RATE        = SAMPLE_RATE_DEF;
    localparam int         QUIET_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] sample;
        logic               active;
    } voice_out_t;

    class voice_tracker;
        logic signed [15:0] sine_lut [DEPTH];
        logic [31:0]        semitone_q16 [12];
        logic [31:0]        phase_acc;
        logic [31:0]        phase_inc;
        logic [15:0]        level;
        logic [15:0]        gain;
        bit                 fading;
        voice_out_t         expected_samples[$];
        int                 errors;
        int                 samples_checked;
        int                 full_releases;

        function new();
            u64_t f;
            for (int i = 0; i < DEPTH; i++)
                sine_lut[i] = sine_value(i);
            semitone_q16[0] = 32'd440 << 16;
            for (int k = 1; k < 12; k++)
            begin
                f = semitone_q16[k - 1];
                f = (f * SEMI_Q30 + (64'd1 << 29)) >> 30;
                semitone_q16[k] = f[31:0];
            end
            phase_acc       = '0;
            phase_inc       = '0;
            level           = '0;
            gain            = '0;
            fading          = 1'b0;
            errors          = 0;
            samples_checked = 0;
            full_releases   = 0;
        endfunction

        // quarter-wave taylor series on a q30 angle
        function logic signed [15:0] sine_value(int i);
            u64_t               frac;
            u64_t               quad_pos;
            u64_t               x;
            u64_t               x2;
            u64_t               term;
            u64_t               mag;
            longint             sum;
            bit                 minus;
            logic signed [15:0] m;
            frac     = (u64_t'(i) << 32) / DEPTH;
            quad_pos = frac & (ONE_Q30 - 1);
            if (frac[30])
                quad_pos = ONE_Q30 - quad_pos;
            x     = (quad_pos * HALF_PI_Q30) >> 30;
            x2    = (x * x) >> 30;
            term  = x;
            sum   = longint'(x);
            minus = 1'b1;
            for (int k = 3; k <= 13; k += 2)
            begin
                term  = ((term * x2) >> 30) / u64_t'((k - 1) * k);
                sum   = minus ? sum - longint'(term) : sum + longint'(term);
                minus = !minus;
            end
            if (sum < 0)
                sum = 0;
            mag = (u64_t'(sum) * 32767 + (64'd1 << 29)) >> 30;
            if (mag > 32767)
                mag = 32767;
            m = mag[15:0];
            return frac[31] ? -m : m;
        endfunction

        function int gain_scale(int a, logic [15:0] g);
            u64_t mag;
            mag = (a < 0) ? -a : a;
            mag = (mag * g + 32768) >> 16;
            return (a < 0) ? -int'(mag) : int'(mag);
        endfunction

        function logic [31:0] note_step(logic [6:0] nt);
            int unsigned u;
            u64_t        num;
            u64_t        den;
            u   = nt + 3;
            num = u64_t'(semitone_q16[u % 12]) << (16 + u / 12);
            den = u64_t'(RATE) << 6;
            num = (num + den / 2) / den;
            return num[31:0];
        endfunction

        function void take_item(logic [1:0] act, logic [6:0] nt, logic [15:0] vel, logic rel);
            voice_out_t r;
            int         s;
            u64_t       p;
            if (act == ACT_START)
            begin
                phase_acc = '0;
                p         = (u64_t'(vel) * LEVEL_MUL + 32768) >> 16;
                level     = p[15:0];
                gain      = '0;
                fading    = 1'b0;
                phase_inc = note_step(nt);
            end
            else if (act == ACT_STOP)
            begin
                if (rel)
                begin
                    if (!fading)
                    begin
                        fading = 1'b1;
                        gain   = GAIN_ONE;
                    end
                end
                else
                    phase_inc = '0;
            end
            else if (act == ACT_TICK)
            begin
                s = 0;
                if (phase_inc != 0)
                begin
                    p = (u64_t'(phase_acc) * DEPTH) >> 32;
                    if (p >= DEPTH)
                        p = DEPTH - 1;
                    s = gain_scale(sine_lut[p], level);
                    if (fading)
                        s = gain_scale(s, gain);
                    phase_acc = phase_acc + phase_inc;
                    if (fading)
                    begin
                        p    = (u64_t'(gain) * DECAY_MUL + 32768) >> 16;
                        gain = p[15:0];
                        if (gain <= GAIN_FLOOR)
                        begin
                            phase_inc = '0;
                            fading    = 1'b0;
                            gain      = '0;
                            full_releases++;
                        end
                    end
                end
                r.sample = s[15:0];
                r.active = (phase_inc != 0);
                expected_samples.push_back(r);
            end
        endfunction

        function void check_sample(logic signed [15:0] got_sample, logic got_active);
            voice_out_t want;
            if (expected_samples.size() == 0)
            begin
                errors++;
                $display("%0t: sample %0d active %0b with no tick item waiting",
                         $time, got_sample, got_active);
                return;
            end
            want = expected_samples.pop_front();
            samples_checked++;
            if (got_sample !== want.sample)
            begin
                errors++;
                $display("%0t: sample mismatch, expected %0d, actual %0d",
                         $time, want.sample, got_sample);
            end
            if (got_active !== want.active)
            begin
                errors++;
                $display("%0t: voice_active mismatch, expected %0b, actual %0b",
                         $time, want.active, got_active);
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               req_valid     = 1'b0;
    logic [1:0]         action        = ACT_TICK;
    logic [6:0]         note          = '0;
    logic [15:0]        velocity      = '0;
    logic               allow_release = 1'b0;
    logic               rsp_ready     = 1'b0;
    logic               req_ready;
    logic               rsp_valid;
    logic signed [15:0] sample;
    logic               voice_active;

    voice_tracker tracker       = new();
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           quiet_cycles  = 0;
    int           items_sent    = 0;
    int           send_pcts [4] = '{0, 70, 0, 30};
    int           stall_pcts [4] = '{0, 0, 70, 30};

    sine_voice_with_release_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .note          (note),
        .velocity      (velocity),
        .allow_release (allow_release),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .sample        (sample),
        .voice_active  (voice_active)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic send_item(logic [1:0] act, logic [6:0] nt, logic [15:0] vel, logic rel);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        action        <= act;
        note          <= nt;
        velocity      <= vel;
        allow_release <= rel;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        tracker.take_item(act, nt, vel, rel);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic start_note(logic [6:0] nt, logic [15:0] vel);
        send_item(ACT_START, nt, vel, 1'($urandom));
    endtask

    task automatic stop_note(logic rel);
        send_item(ACT_STOP, 7'($urandom), 16'($urandom), rel);
    endtask

    task automatic tick_run(int n, bit noisy);
        repeat (n)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(2'($urandom), 7'($urandom), 16'($urandom), 1'($urandom));
            send_item(ACT_TICK, 7'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic play_phrase(int release_tail);
        int          choice;
        logic [15:0] vel;
        case ($urandom_range(0, 7))
            0:       vel = 16'h0000;
            1:       vel = 16'hFFFF;
            default: vel = 16'($urandom);
        endcase
        start_note(7'($urandom_range(0, 127)), vel);
        tick_run($urandom_range(1, 24), 1'b1);
        choice = (release_tail > 0) ? 1 : $urandom_range(0, 9);
        if (choice < 6)
        begin
            stop_note(1'b1);
            tick_run((release_tail > 0) ? release_tail : $urandom_range(1, 30), 1'b1);
            if (choice == 0)
            begin
                stop_note(1'b1);
                tick_run($urandom_range(1, 8), 1'b1);
            end
        end
        else if (choice < 8)
        begin
            stop_note(1'b0);
            tick_run($urandom_range(1, 4), 1'b1);
        end
        else if (choice == 8)
        begin
            // cut, then arm a release on the silent voice
            stop_note(1'b0);
            stop_note(1'b1);
            tick_run($urandom_range(1, 4), 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_sample(sample, voice_active);
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** sine_voice_with_release_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int quota;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items
        tick_run(1, 1'b0);
        stop_note(1'b1);
        tick_run(1, 1'b0);
        start_note(7'd69, 16'hFFFF);
        tick_run(3, 1'b0);
        stop_note(1'b1);
        tick_run(2, 1'b0);
        stop_note(1'b1);
        tick_run(1, 1'b0);
        stop_note(1'b0);
        tick_run(1, 1'b0);
        start_note(7'd0, 16'h0000);
        tick_run(2, 1'b0);
        start_note(7'd127, 16'hFFFF);
        tick_run(2, 1'b0);
        send_item(ACT_UNUSED, 7'h7F, 16'hFFFF, 1'b1);
        tick_run(1, 1'b0);
        stop_note(1'b0);
        tick_run(1, 1'b0);

        // random phrases under each handshake pressure
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            quota         = items_sent + ((p == 0) ? 700 : 350);
            if (p == 0)
                play_phrase(560);
            while (items_sent < quota)
                play_phrase(0);
        end
        req_valid <= 1'b0;

        while (tracker.expected_samples.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d items in four pressure phases, %0d samples checked",
                 items_sent, tracker.samples_checked);
        $display("%0d releases decayed to silence, %0d mismatches",
                 tracker.full_releases, tracker.errors);
        if (tracker.errors == 0)
            $display("** sine_voice_with_release_unit: PASSED **");
        else
            $display("** sine_voice_with_release_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/svr_pkg.sv
rtl/core/svr_ctrl.sv
rtl/core/svr_datapath.sv
rtl/core/sine_voice_with_release_unit.sv
bench/tb_sine_voice_with_release_unit.sv
